// ----- hw/rtl/crq_pkg.sv -----
// Shared types and constants for the coalescing request queue.
// Used by crq_mem, crq_seq and coalescing_request_queue; depends on nothing.
`default_nettype none

package crq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 8;
  localparam int VOL_W       = 8;
  localparam int PCNT_W      = 5;

  typedef enum logic [2:0] {
    ST_APPENDED = 3'd0,
    ST_MERGED   = 3'd1,
    ST_FULL     = 3'd2,
    ST_POPPED   = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_POP_RD,
    S_POP_DAT,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [VOL_W-1:0] vol;
  } entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;
  } mem_req_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   id;
    logic [VOL_W-1:0]  vol;
    logic [PCNT_W-1:0] pcount;
  } result_t;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] n;
    n = IDX_W'(i + 1'b1);
    if (i == IDX_W'(QUEUE_DEPTH - 1)) begin
      n = '0;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/crq_mem.sv -----
// Entry storage: one write port and one registered read port.
// Depends on crq_pkg for the depth, entry layout and request struct.
`default_nettype none

module crq_mem import crq_pkg::*; (
  input  wire logic     clk,
  input  wire mem_req_t req,
  output entry_t        rd_data
);

  entry_t entry_mem [QUEUE_DEPTH];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      entry_mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= entry_mem[req.rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- hw/rtl/crq_seq.sv -----
// Sequencer: ring pointers, count, pipelined id scan over the entry memory,
// merge/append/pop decisions. Depends on crq_pkg; drives crq_mem.
`default_nettype none

module crq_seq import crq_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_kind,
  input  wire logic [ID_W-1:0]  in_sound_id,
  input  wire logic [VOL_W-1:0] in_volume,
  output logic                  res_valid,
  output result_t               res,
  input  wire logic             res_ready,
  output mem_req_t              mem_req,
  input  wire entry_t           rd_data
);

  seq_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic [VOL_W-1:0] vol_r, vol_nxt;
  logic [IDX_W-1:0] iss_r, iss_nxt;
  logic [CNT_W-1:0] iss_n_r, iss_n_nxt;
  logic             cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0] cmp_pos_r, cmp_pos_nxt;
  result_t          res_r, res_nxt;

  logic in_acc;
  logic scan_hit;
  logic scan_end;
  logic vol_gt;
  logic full;
  logic empty;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign scan_hit = cmp_v_r && (rd_data.id == id_r);
  assign scan_end = !scan_hit && (iss_n_r == cnt_r);
  assign vol_gt   = vol_r > rd_data.vol;
  assign full     = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = in_kind ? S_POP_RD : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_hit || scan_end) begin
          state_nxt = S_DONE;
        end
      end
      S_POP_RD:  state_nxt = empty ? S_DONE : S_POP_DAT;
      S_POP_DAT: state_nxt = S_DONE;
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    cnt_nxt     = cnt_r;
    id_nxt      = id_r;
    vol_nxt     = vol_r;
    iss_nxt     = iss_r;
    iss_n_nxt   = iss_n_r;
    cmp_v_nxt   = 1'b0;
    cmp_pos_nxt = cmp_pos_r;
    res_nxt     = res_r;
    mem_req     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          id_nxt    = in_sound_id;
          vol_nxt   = in_volume;
          iss_nxt   = head_r;
          iss_n_nxt = '0;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          // raise the stored volume only when the new one is larger
          mem_req.wr_en   = vol_gt;
          mem_req.wr_addr = cmp_pos_r;
          mem_req.wr_data = '{id: id_r, vol: vol_r};
          res_nxt = '{status: ST_MERGED, id: '0, vol: '0, pcount: PCNT_W'(cnt_r)};
        end else if (scan_end) begin
          if (full) begin
            res_nxt = '{status: ST_FULL, id: '0, vol: '0, pcount: PCNT_W'(cnt_r)};
          end else begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = tail_r;
            mem_req.wr_data = '{id: id_r, vol: vol_r};
            tail_nxt = ring_next(tail_r);
            cnt_nxt  = CNT_W'(cnt_r + 1'b1);
            res_nxt  = '{status: ST_APPENDED, id: '0, vol: '0,
                         pcount: PCNT_W'(cnt_r + 1'b1)};
          end
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = iss_r;
          iss_nxt     = ring_next(iss_r);
          iss_n_nxt   = CNT_W'(iss_n_r + 1'b1);
          cmp_v_nxt   = 1'b1;
          cmp_pos_nxt = iss_r;
        end
      end
      S_POP_RD: begin
        if (empty) begin
          res_nxt = '{status: ST_EMPTY, id: '0, vol: '0, pcount: '0};
        end else begin
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = head_r;
        end
      end
      S_POP_DAT: begin
        head_nxt = ring_next(head_r);
        cnt_nxt  = CNT_W'(cnt_r - 1'b1);
        res_nxt  = '{status: ST_POPPED, id: rd_data.id, vol: rd_data.vol,
                     pcount: PCNT_W'(cnt_r - 1'b1)};
      end
      default: begin
      end
    endcase
  end

  assign res_valid = (state_r == S_DONE);
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      cnt_r   <= '0;
      cmp_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      cmp_v_r <= cmp_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r      <= id_nxt;
    vol_r     <= vol_nxt;
    iss_r     <= iss_nxt;
    iss_n_r   <= iss_n_nxt;
    cmp_pos_r <= cmp_pos_nxt;
    res_r     <= res_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0) |-> (head_r == tail_r))
    else $error("empty queue with head and tail apart");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (iss_n_r <= cnt_r))
    else $error("scan issued past the pending entries");

  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_ready) |=> (state_r == S_IDLE))
    else $error("result handed off but sequencer did not go idle");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/coalescing_request_queue.sv -----
// Coalescing request queue: a push scans the pending entries from the head for a matching id,
// one read per cycle through the single memory read port, then merges, appends or rejects;
// a pop reads the head entry. out_valid rises once the result is in the output register. One
// request is in work at a time: the next is taken only after the last result has been loaded
// into the output register, so output stalls delay it.
// Synchronous active-low reset clears pointers, count, sequencer and output valid;
// entry storage is not cleared, since only pending entries are ever read.
`default_nettype none

module coalescing_request_queue import crq_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // request channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_kind,
  input  wire logic [ID_W-1:0]   in_sound_id,
  input  wire logic [VOL_W-1:0]  in_volume,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             out_status,
  output logic [ID_W-1:0]        out_id,
  output logic [VOL_W-1:0]       out_volume,
  output logic [PCNT_W-1:0]      out_pending_count
);

  mem_req_t mem_req;
  entry_t   rd_data;
  logic     res_valid;
  result_t  res;
  logic     res_ready;

  // Output register: holds the last result until the consumer takes it.
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  // Storage for pending request entries.
  crq_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // Sequencer: scans for a matching id, then merges, appends, rejects or pops.
  crq_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_sound_id (in_sound_id),
    .in_volume   (in_volume),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready),
    .mem_req     (mem_req),
    .rd_data     (rd_data)
  );

  // Load a new result only when the output slot is free or being drained;
  // a stalled result must hold.
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  // Drive the result ports straight from the output register.
  assign out_valid         = out_valid_r;
  assign out_status        = out_res_r.status;
  assign out_id            = out_res_r.id;
  assign out_volume        = out_res_r.vol;
  assign out_pending_count = out_res_r.pcount;

endmodule

`default_nettype wire

// ----- tb/tb_coalescing_request_queue.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for coalescing_request_queue: directed and random push/pop
// requests, with every reply predicted by a local model of the coalescing ring queue.
// Depends on crq_pkg and the coalescing_request_queue RTL.
module tb_coalescing_request_queue;
  import crq_pkg::*;

  localparam logic KIND_PUSH    = 1'b0;
  localparam logic KIND_POP     = 1'b1;
  localparam int   RANDOM_REQS  = 1800;
  localparam int   PHASE_LEN    = 610;     // requests per idling phase
  localparam int   CYCLE_LIMIT  = 400000;
  localparam int   DRAIN_CYCLES = 30;      // longer than the slowest push

  typedef struct {
    logic             kind;
    logic [ID_W-1:0]  id;
    logic [VOL_W-1:0] vol;
    int               phase;
  } request_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   id;
    logic [VOL_W-1:0]  vol;
    logic [PCNT_W-1:0] pcount;
  } queue_reply_t;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_kind = KIND_PUSH;
  logic [ID_W-1:0]   in_sound_id = '0;
  logic [VOL_W-1:0]  in_volume = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        out_status;
  logic [ID_W-1:0]   out_id;
  logic [VOL_W-1:0]  out_volume;
  logic [PCNT_W-1:0] out_pending_count;

  // Requests still to be sent, and replies the model says are on their way.
  request_t     requests_todo[$];
  queue_reply_t replies_due[$];
  int           queued_n = 0;
  int           traffic_phase = 0;
  int           fails = 0;
  int           cycles = 0;
  request_t     next_req;
  queue_reply_t want;

  // Model of the pending ring: ids, volumes, pointers and occupancy.
  logic [ID_W-1:0]  ring_ids[QUEUE_DEPTH];
  logic [VOL_W-1:0] ring_vols[QUEUE_DEPTH];
  logic [IDX_W-1:0] ring_head = '0;
  logic [IDX_W-1:0] ring_tail = '0;
  int               ring_count = 0;

  coalescing_request_queue dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_sound_id       (in_sound_id),
    .in_volume         (in_volume),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_id            (out_id),
    .out_volume        (out_volume),
    .out_pending_count (out_pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle percentage per phase: receiver-heavy idling, then sender-heavy, then none.
  function automatic int idle_pct(input int phase, input logic sender);
    case (phase)
      0: return sender ? 34 : 46;
      1: return sender ? 46 : 34;
      default: return 0;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] step_index(input logic [IDX_W-1:0] i);
    return IDX_W'((int'(i) + 1) % QUEUE_DEPTH);
  endfunction

  // Apply one accepted request to the ring model and return the reply it causes.
  function automatic queue_reply_t apply_request(input logic kind,
                                                 input logic [ID_W-1:0] id,
                                                 input logic [VOL_W-1:0] vol);
    queue_reply_t     r;
    logic             hit;
    logic [IDX_W-1:0] pos;
    r = '0;
    if (kind == KIND_POP) begin
      if (ring_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.id = ring_ids[ring_head];
        r.vol = ring_vols[ring_head];
        ring_head = step_index(ring_head);
        ring_count--;
        r.status = ST_POPPED;
      end
    end else begin
      // Scan head to tail; the first match takes the louder volume.
      hit = 1'b0;
      pos = ring_head;
      for (int k = 0; k < ring_count; k++) begin
        if (!hit && ring_ids[pos] == id) begin
          hit = 1'b1;
          if (vol > ring_vols[pos]) ring_vols[pos] = vol;
        end
        pos = step_index(pos);
      end
      if (hit) begin
        r.status = ST_MERGED;
      end else if (ring_count >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        ring_ids[ring_tail] = id;
        ring_vols[ring_tail] = vol;
        ring_tail = step_index(ring_tail);
        ring_count++;
        r.status = ST_APPENDED;
      end
    end
    r.pcount = PCNT_W'(ring_count);
    return r;
  endfunction

  task automatic add_request(input logic kind, input logic [ID_W-1:0] id,
                             input logic [VOL_W-1:0] vol);
    request_t req;
    req.kind = kind;
    req.id = id;
    req.vol = vol;
    req.phase = (queued_n / PHASE_LEN > 2) ? 2 : queued_n / PHASE_LEN;
    requests_todo.push_back(req);
    queued_n++;
  endtask

  // Driver: predict on acceptance, then present the next request or idle.
  // Hold the payload while stalled; only change it once the request is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        replies_due.push_back(apply_request(in_kind, in_sound_id, in_volume));
      end
      if (!in_valid || !in_stall) begin
        if (requests_todo.size() != 0 &&
            $urandom_range(99) >= idle_pct(requests_todo[0].phase, 1'b1)) begin
          next_req = requests_todo.pop_front();
          in_valid <= 1'b1;
          in_kind <= next_req.kind;
          in_sound_id <= next_req.id;
          in_volume <= next_req.vol;
          traffic_phase <= next_req.phase;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted reply with the oldest prediction,
  // then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          $error("unexpected reply: status %0d id %0d volume %0d pending %0d",
                 out_status, out_id, out_volume, out_pending_count);
          fails++;
        end else begin
          want = replies_due.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            fails++;
          end
          if (out_id !== want.id) begin
            $error("out_id: expected %0d, got %0d", want.id, out_id);
            fails++;
          end
          if (out_volume !== want.vol) begin
            $error("out_volume: expected %0d, got %0d", want.vol, out_volume);
            fails++;
          end
          if (out_pending_count !== want.pcount) begin
            $error("pending_count: expected %0d, got %0d", want.pcount, out_pending_count);
            fails++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < idle_pct(traffic_phase, 1'b0));
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int               made;
    int               seg_len;
    int               push_pct;
    int               id_span;
    logic [ID_W-1:0]  id_base;
    logic [ID_W-1:0]  id;
    logic [VOL_W-1:0] vol;

    // Directed: pop on empty, extreme ids and volumes, merge that raises,
    // keeps an equal and ignores a lower volume, then fill the ring, reject a
    // new id while full, merge while full, and drain the two oldest entries.
    add_request(KIND_POP, 8'h5A, 8'hA5);
    add_request(KIND_PUSH, 8'h00, 8'h00);
    add_request(KIND_PUSH, 8'hFF, 8'hFF);
    add_request(KIND_PUSH, 8'h00, 8'h80);
    add_request(KIND_PUSH, 8'hFF, 8'hFF);
    add_request(KIND_PUSH, 8'hFF, 8'h01);
    for (int i = 1; i <= QUEUE_DEPTH - 2; i++) begin
      add_request(KIND_PUSH, ID_W'(i), VOL_W'(i * 17));
    end
    add_request(KIND_PUSH, 8'hAA, 8'h55);
    add_request(KIND_PUSH, 8'h07, 8'hFE);
    add_request(KIND_POP, 8'hFF, 8'hFF);
    add_request(KIND_POP, 8'h00, 8'h00);

    // Random: segments with their own push bias and id spread, so the ring
    // swings between empty and full and narrow id pools force merges.
    made = 0;
    while (made < RANDOM_REQS) begin
      seg_len = $urandom_range(60, 20);
      case ($urandom_range(3))
        0: push_pct = 25;
        1: push_pct = 50;
        2: push_pct = 75;
        default: push_pct = 95;
      endcase
      case ($urandom_range(2))
        0: id_span = 3;
        1: id_span = 20;
        default: id_span = 255;
      endcase
      id_base = ID_W'($urandom_range(255));
      for (int j = 0; j < seg_len && made < RANDOM_REQS; j++) begin
        id = id_base + ID_W'($urandom_range(id_span));
        case ($urandom_range(9))
          0: vol = '0;
          1: vol = '1;
          default: vol = VOL_W'($urandom_range(255));
        endcase
        if ($urandom_range(99) < push_pct) add_request(KIND_PUSH, id, vol);
        else add_request(KIND_POP, id, vol);
        made++;
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: wait for the last request to be taken and its reply checked,
    // then watch a little longer for stray replies.
    @(posedge clk);
    while (requests_todo.size() != 0 || in_valid || replies_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fails == 0 && replies_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/crq_pkg.sv
hw/rtl/crq_mem.sv
hw/rtl/crq_seq.sv
hw/rtl/coalescing_request_queue.sv
tb/tb_coalescing_request_queue.sv
